### rtl/trajectory_tracking_controller_unit_assert.svh
// assertion macros shared by the controller and the datapath
`ifndef TRAJECTORY_TRACKING_CONTROLLER_UNIT_ASSERT_SVH
`define TRAJECTORY_TRACKING_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TTC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ttc_pkg.sv
// shared types and constants of the trajectory tracking controller
package ttc_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam int EXP_W     = 13;

    // goal tolerances: 0.1 m and pi/18 rad in Q4.12
    localparam logic [16:0] GOAL_POS_TOL  = 17'd410;
    localparam logic [16:0] GOAL_HEAD_TOL = 17'd715;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_ALONG,
        CFG_GAIN_LATERAL,
        CFG_GAIN_HEADING,
        CFG_SPEED_LIMIT,
        CFG_TURN_LIMIT,
        CFG_LATERAL_LIMIT,
        CFG_DISTANCE_LIMIT,
        CFG_HEADING_LIMIT
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
        15'd4096, 15'd4096, 15'd4096, 15'd4096,
        15'd4096, 15'd4096, 15'd2048, 15'd4289
    };

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_TEST,
        ST_ROM,
        ST_WEIGHT,
        ST_GAIN,
        ST_OUT
    } t_ttc_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic square;
        logic test;
        logic rom_read;
        logic weight;
        logic gain;
        logic load_out;
    } t_ttc_cmd;

endpackage

### rtl/ttc_exp_rom.sv
// exp(-h) table over h in [0, 8), Q1.12 entries, registered read
module ttc_exp_rom #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [12:0]                o_data
);

    localparam int IW = $clog2(DEPTH);
    // Q32 step 8/DEPTH
    localparam logic [63:0] STEP = (64'd8 << 32) / DEPTH;

    typedef logic [12:0] t_exp_table [DEPTH];

    // ratio exp(-STEP) by Taylor series, then repeated products, Q32
    function automatic t_exp_table build_table();
        t_exp_table tbl;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] pw;
        term  = 64'd1 << 32;
        ratio = 64'd1 << 32;
        pw    = 64'd1 << 32;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * STEP) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            tbl[k] = 13'((pw * 64'd4096 + (64'd1 << 31)) >> 32);
            pw     = (pw * ratio + (64'd1 << 31)) >> 32;
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_table();

    logic [12:0] r_data;

    // registered table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= EXP_TABLE[i_addr[IW-1:0]];
        end
    end

    assign o_data = r_data;

endmodule

### rtl/ttc_ctrl.sv
// sequencing state machine of the trajectory tracking controller
`include "trajectory_tracking_controller_unit_assert.svh"

module ttc_ctrl import ttc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ttc_cmd o_cmd
);

    t_ttc_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_ttc_cmd   cmd;

    // state and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                n_state    = ST_TEST;
            end
            ST_TEST: begin
                cmd.test = 1'b1;
                n_state  = ST_ROM;
            end
            ST_ROM: begin
                cmd.rom_read = 1'b1;
                n_state      = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                cmd.weight = 1'b1;
                n_state    = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free or being taken
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `TTC_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == ST_SQUARE, "accepted item did not start")
    `TTC_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, r_out_valid, "loaded result not valid")
    `TTC_ASSERT_NOW(a_load_no_overwrite, cmd.load_out, !r_out_valid || i_out_ready, "result overwritten")

endmodule

### rtl/ttc_datapath.sv
// datapath: config registers, products, tracking state and result registers
`include "trajectory_tracking_controller_unit_assert.svh"

module ttc_datapath import ttc_pkg::*; #(
    parameter int MAX_DELAY_TICKS = 60,
    parameter int REPLAN_TICKS    = 100,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ttc_cmd                    i_cmd,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    input  logic signed [DATA_W-1:0]    i_err_x,
    input  logic signed [DATA_W-1:0]    i_err_y,
    input  logic signed [DATA_W-1:0]    i_err_heading,
    input  logic signed [DATA_W-1:0]    i_ref_speed,
    input  logic signed [DATA_W-1:0]    i_ref_turn,
    input  logic                        i_last_point,
    output logic signed [DATA_W-1:0]    o_speed_cmd,
    output logic signed [DATA_W-1:0]    o_turn_cmd,
    output logic                        o_goal_reached,
    output logic                        o_replan_request,
    output logic [5:0]                  o_delay_ticks_out
);

    localparam int DW     = $clog2(MAX_DELAY_TICKS + 1);
    localparam int RW     = $clog2(REPLAN_TICKS + 2);
    localparam int IW     = $clog2(EXP_TABLE_DEPTH);
    localparam int HIDX_W = 27 + IW + 1;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? 17'(-ext) : ext;
    endfunction

    logic [CFG_W-1:0] r_cfg [CFG_COUNT];

    logic signed [15:0] r_ex, r_ey, r_eh, r_vs, r_vt;
    logic               r_fin;

    logic [30:0]        r_sq_x, r_sq_y, r_sq_h;
    logic [29:0]        r_sq_d;
    logic signed [31:0] r_p_speed, r_p_head, r_p_gv;
    logic signed [15:0] r_ey_c;
    logic               r_head_lost, r_goal;

    logic [DW-1:0]      r_delay;
    logic [RW-1:0]      r_replan;
    logic               r_replan_flag;
    logic [IW-1:0]      r_idx;
    logic               r_ev_zero;
    logic signed [15:0] r_speed;
    logic signed [61:0] r_turn_base;

    logic signed [28:0] r_p_ey;
    logic signed [60:0] r_p_big;

    logic signed [15:0] r_speed_cmd, r_turn_cmd;
    logic               r_goal_out, r_replan_out;
    logic [DW-1:0]      r_delay_out;

    logic [EXP_W-1:0]   rom_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ex  <= i_err_x;
            r_ey  <= i_err_y;
            r_eh  <= i_err_heading;
            r_vs  <= i_ref_speed;
            r_vt  <= i_ref_turn;
            r_fin <= i_last_point;
        end
    end

    // squares, gain products, lateral clamp and flags
    logic signed [31:0] sq_x_full, sq_y_full, sq_h_full;
    logic signed [31:0] p_speed, p_head, p_gv;
    logic signed [16:0] ey_ext, ylim_pos, ylim_neg;
    logic signed [15:0] ey_c;
    logic               goal;

    assign sq_x_full = r_ex * r_ex;
    assign sq_y_full = r_ey * r_ey;
    assign sq_h_full = r_eh * r_eh;
    assign p_speed   = $signed({1'b0, r_cfg[CFG_GAIN_ALONG]}) * r_ex;
    assign p_head    = $signed({1'b0, r_cfg[CFG_GAIN_HEADING]}) * r_eh;
    assign p_gv      = $signed({1'b0, r_cfg[CFG_GAIN_LATERAL]}) * r_vs;

    assign ey_ext   = {r_ey[15], r_ey};
    assign ylim_pos = $signed({2'b0, r_cfg[CFG_LATERAL_LIMIT]});
    assign ylim_neg = -ylim_pos;

    always_comb begin
        if (ey_ext > ylim_pos) begin
            ey_c = ylim_pos[15:0];
        end else if (ey_ext < ylim_neg) begin
            ey_c = ylim_neg[15:0];
        end else begin
            ey_c = r_ey;
        end
    end

    assign goal = r_fin && (abs16(r_ex) < GOAL_POS_TOL) && (abs16(r_ey) < GOAL_POS_TOL)
                  && (abs16(r_eh) < GOAL_HEAD_TOL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq_x      <= sq_x_full[30:0];
            r_sq_y      <= sq_y_full[30:0];
            r_sq_h      <= sq_h_full[30:0];
            r_sq_d      <= r_cfg[CFG_DISTANCE_LIMIT] * r_cfg[CFG_DISTANCE_LIMIT];
            r_p_speed   <= p_speed;
            r_p_head    <= p_head;
            r_p_gv      <= p_gv;
            r_ey_c      <= ey_c;
            r_head_lost <= abs16(r_eh) > {2'b0, r_cfg[CFG_HEADING_LIMIT]};
            r_goal      <= goal;
        end
    end

    // tracking test, delay and replan update, table index, speed, turn base
    logic [31:0]        dist_sq;
    logic               lost, mark;
    logic [DW-1:0]      n_delay;
    logic [RW-1:0]      replan_inc, n_replan;
    logic               n_replan_flag;
    logic [HIDX_W-1:0]  hidx_prod;
    logic signed [31:0] speed_sum;
    logic signed [19:0] speed_q, slim_s;
    logic signed [15:0] n_speed;
    logic signed [61:0] turn_base;

    assign dist_sq = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign lost    = (dist_sq > {2'b0, r_sq_d}) || r_head_lost;
    assign mark    = lost && (r_delay >= DW'(MAX_DELAY_TICKS - 1));

    always_comb begin
        n_delay = r_delay;
        if (lost) begin
            n_delay = mark ? DW'(MAX_DELAY_TICKS) : r_delay + 1'b1;
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end
    end

    assign replan_inc = r_replan + 1'b1;

    always_comb begin
        n_replan      = r_replan;
        n_replan_flag = 1'b0;
        if (!r_fin) begin
            if ((replan_inc > RW'(REPLAN_TICKS)) || mark) begin
                n_replan      = '0;
                n_replan_flag = 1'b1;
            end else begin
                n_replan = replan_inc;
            end
        end
    end

    assign hidx_prod = HIDX_W'(r_sq_h[26:0]) * HIDX_W'(EXP_TABLE_DEPTH);

    assign speed_sum = $signed({{4{r_vs[15]}}, r_vs, 12'b0}) + r_p_speed + 32'sd2048;
    assign speed_q   = speed_sum[31:12];
    assign slim_s    = $signed({5'b0, r_cfg[CFG_SPEED_LIMIT]});

    always_comb begin
        if (speed_q > slim_s) begin
            n_speed = slim_s[15:0];
        end else if (speed_q < -20'sd32768) begin
            n_speed = 16'sh8000;
        end else begin
            n_speed = speed_q[15:0];
        end
    end

    assign turn_base = $signed({{10{r_vt[15]}}, r_vt, 36'b0})
                       + $signed({{6{r_p_head[31]}}, r_p_head, 24'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay       <= '0;
            r_replan      <= '0;
            r_replan_flag <= 1'b0;
        end else if (i_cmd.test) begin
            r_delay       <= n_delay;
            r_replan      <= n_replan;
            r_replan_flag <= n_replan_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_idx       <= hidx_prod[27 +: IW];
            r_ev_zero   <= (r_sq_h[30:27] != 4'd0);
            r_speed     <= n_speed;
            r_turn_base <= turn_base;
        end
    end

    // exponential weight table
    ttc_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .i_clk  (i_clk),
        .i_en   (i_cmd.rom_read),
        .i_addr (r_idx),
        .o_data (rom_data)
    );

    // weight times clamped lateral error
    logic signed [13:0] ev_s;
    assign ev_s = r_ev_zero ? 14'sd0 : $signed({1'b0, rom_data});

    always_ff @(posedge i_clk) begin
        if (i_cmd.weight) begin
            r_p_ey <= ev_s * r_ey_c;
        end
    end

    // lateral gain times speed times weighted error
    always_ff @(posedge i_clk) begin
        if (i_cmd.gain) begin
            r_p_big <= r_p_gv * r_p_ey;
        end
    end

    // final turn sum, rounding, saturation and result registers
    logic signed [61:0] turn_acc;
    logic signed [25:0] turn_q, tlim_pos, tlim_neg;
    logic signed [15:0] n_turn;

    assign turn_acc = r_turn_base + {r_p_big[60], r_p_big} + 62'sh8_0000_0000;
    assign turn_q   = turn_acc[61:36];
    assign tlim_pos = $signed({11'b0, r_cfg[CFG_TURN_LIMIT]});
    assign tlim_neg = -tlim_pos;

    always_comb begin
        if (turn_q > tlim_pos) begin
            n_turn = tlim_pos[15:0];
        end else if (turn_q < tlim_neg) begin
            n_turn = tlim_neg[15:0];
        end else begin
            n_turn = turn_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_speed_cmd  <= r_goal ? 16'sd0 : r_speed;
            r_turn_cmd   <= r_goal ? 16'sd0 : n_turn;
            r_goal_out   <= r_goal;
            r_replan_out <= r_replan_flag;
            r_delay_out  <= r_delay;
        end
    end

    logic [DW+5:0] delay_ext;
    assign delay_ext = {6'b0, r_delay_out};

    assign o_speed_cmd       = r_speed_cmd;
    assign o_turn_cmd        = r_turn_cmd;
    assign o_goal_reached    = r_goal_out;
    assign o_replan_request  = r_replan_out;
    assign o_delay_ticks_out = delay_ext[5:0];

    `TTC_ASSERT_NOW(a_delay_bound, 1'b1, r_delay <= DW'(MAX_DELAY_TICKS), "delay count past maximum")
    `TTC_ASSERT_NOW(a_replan_bound, 1'b1, r_replan <= RW'(REPLAN_TICKS), "replan count past period")
    `TTC_ASSERT_NEXT(a_goal_zero, i_cmd.load_out && r_goal, (r_speed_cmd == 16'sd0) && (r_turn_cmd == 16'sd0), "goal result not zero")

endmodule

### rtl/trajectory_tracking_controller_unit.sv
// top level of the trajectory tracking controller
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    err_x, err_y, err_heading, ref_speed,
//                                                 ref_turn, last_point
// output    out        o_out_valid / i_out_ready  speed_cmd, turn_cmd, goal_reached,
//                                                 replan_request, delay_ticks_out
// config    in         i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// items are taken only in the idle state, after the previous item's six datapath steps (squares,
// test, table read, weight, gain product, final sum) are done, so one item is in work at a time
// the result is loaded into the output register by the final sum step
// a next item is taken while a result still waits in the output register
// an output stall holds the sequencer in its last step until the register is free
// synchronous active-low reset clears the sequencer and counters, config to reset values
module trajectory_tracking_controller_unit import ttc_pkg::*; #(
    parameter int MAX_DELAY_TICKS = 60,
    parameter int REPLAN_TICKS    = 100,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [DATA_W-1:0]    i_err_x,
    input  logic signed [DATA_W-1:0]    i_err_y,
    input  logic signed [DATA_W-1:0]    i_err_heading,
    input  logic signed [DATA_W-1:0]    i_ref_speed,
    input  logic signed [DATA_W-1:0]    i_ref_turn,
    input  logic                        i_last_point,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_W-1:0]    o_speed_cmd,
    output logic signed [DATA_W-1:0]    o_turn_cmd,
    output logic                        o_goal_reached,
    output logic                        o_replan_request,
    output logic [5:0]                  o_delay_ticks_out
);

    t_ttc_cmd cmd;

    // sequencer
    ttc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    ttc_datapath #(
        .MAX_DELAY_TICKS (MAX_DELAY_TICKS),
        .REPLAN_TICKS    (REPLAN_TICKS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_err_x           (i_err_x),
        .i_err_y           (i_err_y),
        .i_err_heading     (i_err_heading),
        .i_ref_speed       (i_ref_speed),
        .i_ref_turn        (i_ref_turn),
        .i_last_point      (i_last_point),
        .o_speed_cmd       (o_speed_cmd),
        .o_turn_cmd        (o_turn_cmd),
        .o_goal_reached    (o_goal_reached),
        .o_replan_request  (o_replan_request),
        .o_delay_ticks_out (o_delay_ticks_out)
    );

endmodule

### tb/trajectory_tracking_controller_unit_tb.sv
// self-checking testbench of the trajectory tracking controller unit
module trajectory_tracking_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttc_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int MAX_DELAY      = 60;
    localparam int REPLAN_LIMIT   = 100;
    localparam int LUT_DEPTH      = 256;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_SLACK    = 12;
    localparam int IDLE_PERCENT   = 23;
    localparam int MISMATCH_SHOWN = 30;
    localparam int TIMEOUT_NS     = 3_000_000;

    // one control tick as offered on the input channel
    typedef struct packed {
        logic [DATA_W-1:0] err_x, err_y, err_heading, ref_speed, ref_turn;
        logic              last_point;
    } t_ctl_tick;

    // one command as returned on the output channel
    typedef struct packed {
        logic [DATA_W-1:0] speed_cmd, turn_cmd;
        logic              goal_reached, replan_request;
        logic [5:0]        delay_ticks;
    } t_ctl_cmd;

    typedef enum {TICK_TRACK, TICK_LOST, TICK_GOAL, TICK_WILD} t_tick_kind;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_addr = '0;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_err_x = '0;
    logic signed [DATA_W-1:0] i_err_y = '0;
    logic signed [DATA_W-1:0] i_err_heading = '0;
    logic signed [DATA_W-1:0] i_ref_speed = '0;
    logic signed [DATA_W-1:0] i_ref_turn = '0;
    logic                     i_last_point = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_speed_cmd;
    logic signed [DATA_W-1:0] o_turn_cmd;
    logic                     o_goal_reached;
    logic                     o_replan_request;
    logic [5:0]               o_delay_ticks_out;

    // predictor copy of registers, counters and exponential table
    logic [CFG_W-1:0] cfg_shadow [CFG_COUNT];
    int               delay_ticks = 0;
    int               replan_ticks = 0;
    int unsigned      exp_lut [LUT_DEPTH];

    t_ctl_tick tick_pend_q[$];
    t_ctl_cmd  cmd_expect_q[$];

    bit no_gaps = 1'b0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int n_errors = 0;
    int n_ticks = 0;
    int n_cmds = 0;
    int n_goals = 0;
    int n_replans = 0;
    int peak_delay = 0;
    int n_settings = 1;

    trajectory_tracking_controller_unit #(
        .MAX_DELAY_TICKS (MAX_DELAY),
        .REPLAN_TICKS    (REPLAN_LIMIT),
        .EXP_TABLE_DEPTH (LUT_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_err_x           (i_err_x),
        .i_err_y           (i_err_y),
        .i_err_heading     (i_err_heading),
        .i_ref_speed       (i_ref_speed),
        .i_ref_turn        (i_ref_turn),
        .i_last_point      (i_last_point),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_speed_cmd       (o_speed_cmd),
        .o_turn_cmd        (o_turn_cmd),
        .o_goal_reached    (o_goal_reached),
        .o_replan_request  (o_replan_request),
        .o_delay_ticks_out (o_delay_ticks_out)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // exp(-8k/depth) in Q12: series for the step ratio in Q32, then repeated products
    function automatic void build_exp_lut();
        longint unsigned step, term, ratio, pw, n;
        int k;
        step  = (64'd8 << 32) / LUT_DEPTH;
        term  = 64'd1 << 32;
        ratio = term;
        pw    = 64'd1 << 32;
        for (n = 1; n <= 24; n++) begin
            term = ((term * step) >> 32) / n;
            if (n % 2 == 1) ratio = ratio - term;
            else ratio = ratio + term;
        end
        for (k = 0; k < LUT_DEPTH; k++) begin
            exp_lut[k] = 32'((pw * 64'd4096 + (64'd1 << 31)) >> 32);
            pw = (pw * ratio + (64'd1 << 31)) >> 32;
        end
    endfunction

    // expected command of one tick, advances the delay and replan counters
    function automatic t_ctl_cmd predict_cmd(t_ctl_tick tk);
        longint ex, ey, eh, vs, vt;
        longint ga, gl, gh, slim, tlim, ylim, dlim, hlim;
        longint ev, acc, spd, trn;
        longint unsigned h2, idx;
        bit mark, goal;
        t_ctl_cmd c;
        ex   = $signed(tk.err_x);
        ey   = $signed(tk.err_y);
        eh   = $signed(tk.err_heading);
        vs   = $signed(tk.ref_speed);
        vt   = $signed(tk.ref_turn);
        ga   = cfg_shadow[CFG_GAIN_ALONG];
        gl   = cfg_shadow[CFG_GAIN_LATERAL];
        gh   = cfg_shadow[CFG_GAIN_HEADING];
        slim = cfg_shadow[CFG_SPEED_LIMIT];
        tlim = cfg_shadow[CFG_TURN_LIMIT];
        ylim = cfg_shadow[CFG_LATERAL_LIMIT];
        dlim = cfg_shadow[CFG_DISTANCE_LIMIT];
        hlim = cfg_shadow[CFG_HEADING_LIMIT];
        mark = 1'b0;
        spd  = 0;
        trn  = 0;

        // tracking delay: up while lost, down otherwise
        if (ex * ex + ey * ey > dlim * dlim || mag(eh) > hlim) begin
            if (delay_ticks < MAX_DELAY) delay_ticks++;
            if (delay_ticks >= MAX_DELAY) begin
                delay_ticks = MAX_DELAY;
                mark = 1'b1;
            end
        end else if (delay_ticks > 0) begin
            delay_ticks--;
        end

        goal = tk.last_point && mag(ex) < longint'(GOAL_POS_TOL) &&
               mag(ey) < longint'(GOAL_POS_TOL) && mag(eh) < longint'(GOAL_HEAD_TOL);

        // commands, zero once the goal is reached
        if (!goal) begin
            ev = 0;
            h2 = eh * eh;
            if (h2 < (64'd8 << 24)) begin
                idx = (h2 * LUT_DEPTH) >> 27;
                if (idx < LUT_DEPTH) ev = exp_lut[idx];
            end
            spd = (vs * 4096 + ga * ex + 2048) >>> 12;
            if (spd > slim) spd = slim;
            if (spd < -32768) spd = -32768;
            if (ey > ylim) ey = ylim;
            if (ey < -ylim) ey = -ylim;
            acc = vt * (64'sd1 << 36) + gh * eh * (64'sd1 << 24) + gl * vs * ev * ey;
            trn = (acc + (64'sd1 << 35)) >>> 36;
            if (trn > tlim) trn = tlim;
            if (trn < -tlim) trn = -tlim;
        end

        // replan period counts only non-final points
        c.replan_request = 1'b0;
        if (!tk.last_point) begin
            replan_ticks++;
            if (replan_ticks > REPLAN_LIMIT || mark) begin
                replan_ticks = 0;
                c.replan_request = 1'b1;
            end
        end

        c.speed_cmd    = spd[15:0];
        c.turn_cmd     = trn[15:0];
        c.goal_reached = goal;
        c.delay_ticks  = 6'(delay_ticks);
        return c;
    endfunction

    function automatic int rand_signed(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // random tick shaped by kind and the current limits
    function automatic t_ctl_tick rand_tick(t_tick_kind kind);
        t_ctl_tick tk;
        int dl, hl;
        tk.err_x       = 16'($urandom());
        tk.err_y       = 16'($urandom());
        tk.err_heading = 16'($urandom());
        tk.ref_speed   = 16'($urandom());
        tk.ref_turn    = 16'($urandom());
        tk.last_point  = 1'($urandom_range(1));
        if ($urandom_range(1) == 0) begin
            tk.ref_speed = 16'(rand_signed(8192));
            tk.ref_turn  = 16'(rand_signed(8192));
        end
        dl = int'(cfg_shadow[CFG_DISTANCE_LIMIT]) * 7 / 10;
        hl = int'(cfg_shadow[CFG_HEADING_LIMIT]);
        case (kind)
            TICK_TRACK: begin
                tk.err_x       = 16'(rand_signed(dl));
                tk.err_y       = 16'(rand_signed(dl));
                tk.err_heading = 16'(rand_signed(hl));
                tk.last_point  = ($urandom_range(9) == 0);
            end
            TICK_LOST: begin
                tk.last_point = ($urandom_range(7) == 0);
            end
            TICK_GOAL: begin
                tk.err_x       = 16'(rand_signed(420));
                tk.err_y       = 16'(rand_signed(420));
                tk.err_heading = 16'(rand_signed(725));
                tk.last_point  = 1'b1;
            end
            TICK_WILD: begin
            end
            default: begin
            end
        endcase
        return tk;
    endfunction

    task automatic push_tick(int ex, int ey, int eh, int vs, int vt, bit lp);
        tick_pend_q.push_back({16'(ex), 16'(ey), 16'(eh), 16'(vs), 16'(vt), lp});
    endtask

    // bursts of one kind so the delay counter can climb to its cap
    task automatic push_random(int count);
        t_tick_kind kind;
        int pick, burst;
        while (count > 0) begin
            pick = $urandom_range(99);
            if (pick < 40) kind = TICK_TRACK;
            else if (pick < 65) kind = TICK_LOST;
            else if (pick < 80) kind = TICK_GOAL;
            else kind = TICK_WILD;
            if (kind == TICK_LOST && $urandom_range(3) == 0) burst = $urandom_range(40, 75);
            else burst = $urandom_range(1, 20);
            repeat (burst) begin
                if (count > 0) begin
                    tick_pend_q.push_back(rand_tick(kind));
                    count--;
                end
            end
        end
    endtask

    // wait until every tick is through and every command has come back
    task automatic wait_drained();
        while (tick_pend_q.size() != 0 || i_in_valid || cmd_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // write all registers, block idle
    task automatic load_settings(logic [CFG_W-1:0] vals [CFG_COUNT]);
        int i;
        for (i = 0; i < CFG_COUNT; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= t_cfg_idx'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            cfg_shadow[i] = vals[i];
        end
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MISMATCH_SHOWN)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // input driver fed from the pending queue
    always @(posedge i_clk) begin
        t_ctl_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (tick_pend_q.size() != 0 &&
                (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
                nxt = tick_pend_q.pop_front();
                i_err_x       <= nxt.err_x;
                i_err_y       <= nxt.err_y;
                i_err_heading <= nxt.err_heading;
                i_ref_speed   <= nxt.ref_speed;
                i_ref_turn    <= nxt.ref_turn;
                i_last_point  <= nxt.last_point;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // monitor: check each output transfer, predict each input transfer
    always @(posedge i_clk) begin
        t_ctl_cmd got, want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_speed_cmd, o_turn_cmd, o_goal_reached, o_replan_request,
                       o_delay_ticks_out};
                n_cmds++;
                n_goals   += got.goal_reached;
                n_replans += got.replan_request;
                if (got.delay_ticks > peak_delay) peak_delay = got.delay_ticks;
                if (cmd_expect_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected command, expected none actual %h", $time, got);
                end else begin
                    want = cmd_expect_q.pop_front();
                    check_field("speed_cmd", want.speed_cmd, got.speed_cmd);
                    check_field("turn_cmd", want.turn_cmd, got.turn_cmd);
                    check_field("goal_reached", 16'(want.goal_reached),
                                16'(got.goal_reached));
                    check_field("replan_request", 16'(want.replan_request),
                                16'(got.replan_request));
                    check_field("delay_ticks_out", 16'(want.delay_ticks),
                                16'(got.delay_ticks));
                end
            end
            if (i_in_valid && o_in_ready) begin
                cmd_expect_q.push_back(predict_cmd({i_err_x, i_err_y, i_err_heading,
                                                    i_ref_speed, i_ref_turn, i_last_point}));
                n_ticks++;
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [CFG_W-1:0] vals [CFG_COUNT];
        int p, i;
        build_exp_lut();
        for (i = 0; i < CFG_COUNT; i++) cfg_shadow[i] = CFG_RESET[i];
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed ticks under reset values
        push_tick(0, 0, 0, 0, 0, 0);
        push_tick(32767, 32767, 32767, 32767, 32767, 0);
        push_tick(-32768, -32768, -32768, -32768, -32768, 0);
        push_tick(-32768, -32768, -32768, -32768, -32768, 1);
        push_tick(409, -409, 714, 1000, 500, 1);
        push_tick(-409, 409, -714, -1000, -500, 1);
        push_tick(410, 0, 0, 4096, 0, 1);
        push_tick(0, 0, 715, 4096, 0, 1);
        push_tick(100, 100, 100, 4096, 0, 0);
        push_tick(2048, 0, 0, 2048, 0, 0);
        push_tick(2049, 0, 0, 2048, 0, 0);
        push_tick(1448, 1448, 0, 4096, 0, 0);
        push_tick(1449, 1449, 0, 4096, 0, 0);
        push_tick(0, 0, 4289, 4096, 0, 0);
        push_tick(0, 0, -4290, 4096, 0, 0);
        push_tick(0, 1000, 11585, 8192, 0, 0);
        push_tick(0, 1000, 11586, 8192, 0, 0);
        push_tick(0, -1000, -11585, 8192, 0, 0);
        push_tick(0, 8000, 0, 4096, 0, 0);
        push_tick(0, -8000, -3000, 8192, -20000, 0);
        push_tick(300, -200, 50, 4096, 100, 0);
        push_tick(100, 500, 4000, 4096, 0, 0);
        wait_drained();

        // register extremes
        for (i = 0; i < CFG_COUNT; i++) vals[i] = '0;
        load_settings(vals);
        push_random(30);
        wait_drained();
        for (i = 0; i < CFG_COUNT; i++) vals[i] = '1;
        load_settings(vals);
        push_random(30);
        wait_drained();

        // random settings, the last pass with reset values
        for (p = 0; p < 5; p++) begin
            vals[CFG_GAIN_ALONG]     = 15'($urandom_range(0, 12288));
            vals[CFG_GAIN_LATERAL]   = 15'($urandom_range(0, 12288));
            vals[CFG_GAIN_HEADING]   = 15'($urandom_range(0, 12288));
            vals[CFG_SPEED_LIMIT]    = 15'($urandom_range(0, 32767));
            vals[CFG_TURN_LIMIT]     = 15'($urandom_range(0, 32767));
            vals[CFG_LATERAL_LIMIT]  = 15'($urandom_range(0, 16384));
            vals[CFG_DISTANCE_LIMIT] = 15'($urandom_range(200, 12000));
            vals[CFG_HEADING_LIMIT]  = 15'($urandom_range(300, 16000));
            if (p == 4) begin
                for (i = 0; i < CFG_COUNT; i++) vals[i] = CFG_RESET[i];
            end
            load_settings(vals);
            if (p == 0) begin
                // back-to-back offers against a long output hold-off
                no_gaps = 1'b1;
                hold_token++;
                push_random(94);
                wait_drained();
                no_gaps = 1'b0;
            end else if (p == 2) begin
                // sender pauses mid-phase until everything is back
                push_random(47);
                wait_drained();
                push_random(47);
                wait_drained();
            end else begin
                push_random(94);
                wait_drained();
            end
        end

        repeat (DRAIN_SLACK) @(negedge i_clk);
        $display("ran %0d ticks under %0d register settings, %0d commands checked",
                 n_ticks, n_settings, n_cmds);
        $display("goal hits %0d, replan requests %0d, peak delay %0d ticks, %0d mismatches",
                 n_goals, n_replans, peak_delay, n_errors);
        if (n_errors == 0) begin
            $display("** trajectory_tracking_controller_unit: PASSED **");
        end else begin
            $display("** trajectory_tracking_controller_unit: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d commands outstanding", cmd_expect_q.size());
        $display("** trajectory_tracking_controller_unit: FAILED **");
        $finish;
    end

endmodule
